// File: rtl/core/rfa_pkg.sv
// Shared types and codes for the rational fraction ALU.
`default_nettype none
package rfa_pkg;

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_SUB = 2'd1;
  localparam logic [1:0] CMD_MUL = 2'd2;
  localparam logic [1:0] CMD_DIV = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [1:0] ST_BAD_OP   = 2'd2;
  localparam logic [1:0] ST_DIV_ZERO = 2'd3;

  localparam int RES_NUM_W  = 32;
  localparam int RES_DEN_W  = 30;
  localparam int WHOLE_W    = 32;
  localparam int FRAC_NUM_W = 31;

  // classification of one queued word
  typedef struct packed {
    logic [1:0] cmd;
    logic [1:0] status;
    logic       a_neg;
    logic       b_neg;
  } rfa_ctl_t;

endpackage
`default_nettype wire

// File: rtl/core/rfa_front.sv
// Front end: takes operands apart into sign and magnitude and classifies errors.
`default_nettype none
module rfa_front
  import rfa_pkg::*;
#(
  parameter int W = 16
) (
  input  wire logic                start,
  input  wire logic                busy,
  input  wire logic [1:0]          in_cmd,
  input  wire logic signed [W-1:0] in_a_num,
  input  wire logic signed [W-1:0] in_a_den,
  input  wire logic signed [W-1:0] in_b_num,
  input  wire logic signed [W-1:0] in_b_den,
  output logic                     push,
  output rfa_ctl_t                 ctl,
  output logic [4*W-1:0]           mags
);

  logic [W-1:0] an_mag, ad_mag, bn_mag, bd_mag;

  assign an_mag = in_a_num[W-1] ? (~in_a_num + W'(1)) : in_a_num;
  assign ad_mag = in_a_den[W-1] ? (~in_a_den + W'(1)) : in_a_den;
  assign bn_mag = in_b_num[W-1] ? (~in_b_num + W'(1)) : in_b_num;
  assign bd_mag = in_b_den[W-1] ? (~in_b_den + W'(1)) : in_b_den;

  assign push = start && !busy;
  assign mags = {an_mag, ad_mag, bn_mag, bd_mag};

  always_comb begin
    ctl.cmd   = in_cmd;
    ctl.a_neg = (in_a_num[W-1] ^ in_a_den[W-1]) && (an_mag != '0);
    ctl.b_neg = (in_b_num[W-1] ^ in_b_den[W-1]) && (bn_mag != '0);
    if (ad_mag == '0 || bd_mag == '0) begin
      ctl.status = ST_ZERO_DEN;
    end else if (in_cmd == CMD_DIV && bn_mag == '0) begin
      ctl.status = ST_DIV_ZERO;
    end else begin
      ctl.status = ST_OK;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/rfa_queue.sv
// Two-entry queue between front and back end.
`default_nettype none
module rfa_queue #(
  parameter int DW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire logic [DW-1:0] push_data,
  input  wire logic          pop,
  output logic [DW-1:0]      pop_data,
  output logic               full,
  output logic               empty
);

  logic [DW-1:0] mem_r [2];
  logic          wr_ptr_r, rd_ptr_r;
  logic [1:0]    count_r;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/rfa_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module rfa_div #(
  parameter int N = 33
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [N-1:0] dividend,
  input  wire logic [N-1:0] divisor,
  output logic              done,
  output logic [N-1:0]      quot,
  output logic [N-1:0]      rem
);

  localparam int CW = $clog2(N + 1);

  logic [N-1:0] q_r, r_r, d_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [N:0]    shifted;
  logic          fits;

  assign shifted = {r_r, q_r[N-1]};
  assign fits    = (shifted >= {1'b0, d_r});
  assign done    = done_r;
  assign quot    = q_r;
  assign rem     = r_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(N - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= dividend;
      r_r <= '0;
      d_r <= divisor;
    end else if (busy_r) begin
      q_r <= {q_r[N-2:0], fits};
      r_r <= fits ? N'(shifted - {1'b0, d_r}) : shifted[N-1:0];
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/rfa_back.sv
// Back end: lcm, products, gcd reduction and mixed form, on a shared divider.
`default_nettype none
module rfa_back
  import rfa_pkg::*;
#(
  parameter int W = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_empty,
  input  wire rfa_ctl_t       q_ctl,
  input  wire logic [4*W-1:0] q_mags,
  output logic                q_pop,
  output logic                out_valid,
  output logic [1:0]          out_status,
  output logic signed [RES_NUM_W-1:0]  out_res_num,
  output logic [RES_DEN_W-1:0]         out_res_den,
  output logic signed [WHOLE_W-1:0]    out_whole_part,
  output logic signed [FRAC_NUM_W-1:0] out_frac_num
);

  localparam int MW = 2 * W + 1;
  localparam int KW = $clog2(MW + 1);
  localparam int EW = (MW > 32) ? MW : 32;

  typedef enum logic [3:0] {
    S_IDLE, S_G0, S_QA, S_QB, S_M1, S_M2, S_M3, S_SUM,
    S_GR, S_RN, S_RD, S_WH, S_DONE
  } state_t;

  state_t        state_r;
  rfa_ctl_t      ctl_r;
  logic [W-1:0]  an_r, ad_r, bn_r, bd_r, qa_r, qb_r;
  logic [2*W-1:0] t1_r, t2_r;
  logic [MW-1:0] num_r, den_r, g_r, wh_r, rem_r;
  logic          num_neg_r;
  logic [MW-1:0] gx_r, gy_r, gx_nxt, gy_nxt, g_val;
  logic [KW-1:0] gk_r, gk_nxt;
  logic          div_start_r;
  logic [MW-1:0] div_n_r, div_d_r, quot, rem;
  logic          div_done;
  logic [W-1:0]  mul_a, mul_b;
  logic [2*W-1:0] prod;
  logic          addsub, t2_neg, sum_neg;
  logic [MW-1:0] sum_mag;
  logic [EW-1:0] num_ext, wh_ext, rem_ext, den_ext;
  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [RES_NUM_W-1:0]  out_res_num_r;
  logic [RES_DEN_W-1:0]  out_res_den_r;
  logic [WHOLE_W-1:0]    out_whole_part_r;
  logic [FRAC_NUM_W-1:0] out_frac_num_r;

  rfa_div #(.N(MW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (div_n_r),
    .divisor  (div_d_r),
    .done     (div_done),
    .quot     (quot),
    .rem      (rem)
  );

  assign q_pop  = (state_r == S_IDLE) && !q_empty;
  assign addsub = (ctl_r.cmd == CMD_ADD) || (ctl_r.cmd == CMD_SUB);

  // binary gcd step
  assign g_val = gx_r << gk_r;
  always_comb begin
    gx_nxt = gx_r;
    gy_nxt = gy_r;
    gk_nxt = gk_r;
    if (!gx_r[0] && !gy_r[0]) begin
      gx_nxt = gx_r >> 1;
      gy_nxt = gy_r >> 1;
      gk_nxt = gk_r + KW'(1);
    end else if (!gx_r[0]) begin
      gx_nxt = gx_r >> 1;
    end else if (!gy_r[0]) begin
      gy_nxt = gy_r >> 1;
    end else if (gx_r > gy_r) begin
      gx_nxt = gx_r - gy_r;
    end else begin
      gy_nxt = gy_r - gx_r;
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_M1: begin
        mul_a = an_r;
        mul_b = addsub ? qb_r : ((ctl_r.cmd == CMD_MUL) ? bn_r : bd_r);
      end
      S_M2: begin
        mul_a = addsub ? bn_r : ad_r;
        mul_b = addsub ? qa_r : ((ctl_r.cmd == CMD_MUL) ? bd_r : bn_r);
      end
      S_M3: begin
        mul_a = qa_r;
        mul_b = bd_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign prod = mul_a * mul_b;

  // signed-magnitude add of the two scaled numerators
  assign t2_neg = ctl_r.b_neg ^ (ctl_r.cmd == CMD_SUB);
  always_comb begin
    if (ctl_r.a_neg == t2_neg) begin
      sum_mag = MW'(t1_r) + MW'(t2_r);
      sum_neg = ctl_r.a_neg;
    end else if (t1_r >= t2_r) begin
      sum_mag = MW'(t1_r - t2_r);
      sum_neg = ctl_r.a_neg;
    end else begin
      sum_mag = MW'(t2_r - t1_r);
      sum_neg = t2_neg;
    end
  end

  assign num_ext = EW'(num_r);
  assign wh_ext  = EW'(wh_r);
  assign rem_ext = EW'(rem_r);
  assign den_ext = EW'(den_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            ctl_r <= q_ctl;
            {an_r, ad_r, bn_r, bd_r} <= q_mags;
            gx_r <= MW'(q_mags[3*W-1:2*W]);
            gy_r <= MW'(q_mags[W-1:0]);
            gk_r <= '0;
            if (q_ctl.status != ST_OK) begin
              num_r     <= '0;
              num_neg_r <= 1'b0;
              den_r     <= '0;
              wh_r      <= '0;
              rem_r     <= '0;
              state_r   <= S_DONE;
            end else if (q_ctl.cmd == CMD_ADD || q_ctl.cmd == CMD_SUB) begin
              state_r <= S_G0;
            end else begin
              state_r <= S_M1;
            end
          end
        end
        S_G0: begin
          if (gx_r == gy_r) begin
            g_r         <= g_val;
            div_n_r     <= MW'(ad_r);
            div_d_r     <= g_val;
            div_start_r <= 1'b1;
            state_r     <= S_QA;
          end else begin
            gx_r <= gx_nxt;
            gy_r <= gy_nxt;
            gk_r <= gk_nxt;
          end
        end
        S_QA: begin
          if (div_done) begin
            qa_r        <= quot[W-1:0];
            div_n_r     <= MW'(bd_r);
            div_d_r     <= g_r;
            div_start_r <= 1'b1;
            state_r     <= S_QB;
          end
        end
        S_QB: begin
          if (div_done) begin
            qb_r    <= quot[W-1:0];
            state_r <= S_M1;
          end
        end
        S_M1: begin
          t1_r      <= prod;
          num_r     <= MW'(prod);
          num_neg_r <= (ctl_r.a_neg ^ ctl_r.b_neg) && (prod != '0);
          state_r   <= S_M2;
        end
        S_M2: begin
          t2_r <= prod;
          if (addsub) begin
            state_r <= S_M3;
          end else if (num_r == '0) begin
            den_r   <= MW'(1);
            wh_r    <= '0;
            rem_r   <= '0;
            state_r <= S_DONE;
          end else begin
            den_r   <= MW'(prod);
            gx_r    <= num_r;
            gy_r    <= MW'(prod);
            gk_r    <= '0;
            state_r <= S_GR;
          end
        end
        S_M3: begin
          den_r   <= MW'(prod);
          state_r <= S_SUM;
        end
        S_SUM: begin
          num_r     <= sum_mag;
          num_neg_r <= sum_neg && (sum_mag != '0);
          if (sum_mag == '0) begin
            den_r   <= MW'(1);
            wh_r    <= '0;
            rem_r   <= '0;
            state_r <= S_DONE;
          end else begin
            gx_r    <= sum_mag;
            gy_r    <= den_r;
            gk_r    <= '0;
            state_r <= S_GR;
          end
        end
        S_GR: begin
          if (gx_r == gy_r) begin
            g_r         <= g_val;
            div_n_r     <= num_r;
            div_d_r     <= g_val;
            div_start_r <= 1'b1;
            state_r     <= S_RN;
          end else begin
            gx_r <= gx_nxt;
            gy_r <= gy_nxt;
            gk_r <= gk_nxt;
          end
        end
        S_RN: begin
          if (div_done) begin
            num_r       <= quot;
            div_n_r     <= den_r;
            div_d_r     <= g_r;
            div_start_r <= 1'b1;
            state_r     <= S_RD;
          end
        end
        S_RD: begin
          if (div_done) begin
            den_r       <= quot;
            div_n_r     <= num_r;
            div_d_r     <= quot;
            div_start_r <= 1'b1;
            state_r     <= S_WH;
          end
        end
        S_WH: begin
          if (div_done) begin
            wh_r    <= quot;
            rem_r   <= rem;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          out_valid_r      <= 1'b1;
          out_status_r     <= ctl_r.status;
          out_res_num_r    <= num_neg_r ? RES_NUM_W'(-num_ext) : RES_NUM_W'(num_ext);
          out_res_den_r    <= den_ext[RES_DEN_W-1:0];
          out_whole_part_r <= num_neg_r ? WHOLE_W'(-wh_ext) : WHOLE_W'(wh_ext);
          out_frac_num_r   <= num_neg_r ? FRAC_NUM_W'(-rem_ext) : FRAC_NUM_W'(rem_ext);
          state_r          <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_res_num    = out_res_num_r;
  assign out_res_den    = out_res_den_r;
  assign out_whole_part = out_whole_part_r;
  assign out_frac_num   = out_frac_num_r;

endmodule
`default_nettype wire

// File: rtl/core/rational_fraction_alu.sv
// Rational fraction ALU top level.
// Usage:
//   Input: drive in_cmd (add, sub, mul, div) and the two fractions
//   in_a_num/in_a_den, in_b_num/in_b_den; a word is taken on a rising edge
//   with start high and busy low. Up to two words queue ahead of the
//   arithmetic engine; busy is high while that queue is full.
//   Output: each word yields one result, shown for exactly one cycle with
//   out_valid high: status, reduced numerator and positive denominator,
//   truncated whole part and remainder numerator of the mixed form.
//   Errors (zero denominator, divide by zero) go from idle straight to the
//   result state; a zero product or sum skips the gcd reduction and the
//   mixed-form divides.
//   Engine: one shared bit-serial divider of 2*W+1 bits and a binary gcd
//   loop. Multiply and divide take three divides and one gcd loop; add
//   and subtract take five divides and a second gcd loop. One item is
//   processed at a time.
//   Reset: rst_n low empties the queue and idles the engine; no result is
//   shown in the cycle after reset. The receiver cannot stall results.
`default_nettype none
module rational_fraction_alu
  import rfa_pkg::*;
#(
  parameter int OPERAND_WIDTH = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [1:0]                      in_cmd,
  input  wire logic signed [OPERAND_WIDTH-1:0] in_a_num,
  input  wire logic signed [OPERAND_WIDTH-1:0] in_a_den,
  input  wire logic signed [OPERAND_WIDTH-1:0] in_b_num,
  input  wire logic signed [OPERAND_WIDTH-1:0] in_b_den,
  output logic                                 out_valid,
  output logic [1:0]                           out_status,
  output logic signed [RES_NUM_W-1:0]          out_res_num,
  output logic [RES_DEN_W-1:0]                 out_res_den,
  output logic signed [WHOLE_W-1:0]            out_whole_part,
  output logic signed [FRAC_NUM_W-1:0]         out_frac_num
);

  localparam int W  = OPERAND_WIDTH;
  localparam int DW = $bits(rfa_ctl_t) + 4 * W;

  logic           push, pop, q_full, q_empty;
  rfa_ctl_t       f_ctl, q_ctl;
  logic [4*W-1:0] f_mags, q_mags;
  logic [DW-1:0]  q_data;

  assign busy = q_full;

  rfa_front #(.W(W)) u_front (
    .start    (start),
    .busy     (q_full),
    .in_cmd   (in_cmd),
    .in_a_num (in_a_num),
    .in_a_den (in_a_den),
    .in_b_num (in_b_num),
    .in_b_den (in_b_den),
    .push     (push),
    .ctl      (f_ctl),
    .mags     (f_mags)
  );

  rfa_queue #(.DW(DW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({f_ctl, f_mags}),
    .pop       (pop),
    .pop_data  (q_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  assign {q_ctl, q_mags} = q_data;

  rfa_back #(.W(W)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_ctl          (q_ctl),
    .q_mags         (q_mags),
    .q_pop          (pop),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_res_num    (out_res_num),
    .out_res_den    (out_res_den),
    .out_whole_part (out_whole_part),
    .out_frac_num   (out_frac_num)
  );

endmodule
`default_nettype wire

// File: rtl/core/rfa_checker.sv
// Port-level checks for the rational fraction ALU, bound to the top level.
`default_nettype none
module rfa_checker
  import rfa_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  out_valid,
  input wire logic [1:0]            out_status,
  input wire logic [RES_NUM_W-1:0]  out_res_num,
  input wire logic [RES_DEN_W-1:0]  out_res_den,
  input wire logic [WHOLE_W-1:0]    out_whole_part,
  input wire logic [FRAC_NUM_W-1:0] out_frac_num
);

  a_no_bad_op: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != ST_BAD_OP)
    else $error("invalid-op status reported");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |->
      (out_res_num == '0 && out_res_den == '0 && out_whole_part == '0
       && out_frac_num == '0))
    else $error("error result carries nonzero fields");

  a_zero_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_OK && out_res_num == '0) |->
      (out_res_den == RES_DEN_W'(1) && out_whole_part == '0 && out_frac_num == '0))
    else $error("zero result not reduced to 0/1");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("results on back-to-back cycles");

  a_quiet_after_reset: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> !out_valid)
    else $error("result right after reset");

endmodule

bind rational_fraction_alu rfa_checker u_rfa_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_status     (out_status),
  .out_res_num    (out_res_num),
  .out_res_den    (out_res_den),
  .out_whole_part (out_whole_part),
  .out_frac_num   (out_frac_num)
);
`default_nettype wire

// File: tb/tb_top.sv
// Testbench for rational_fraction_alu: predicted fraction results checked word by word.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import rfa_pkg::*;

  localparam int W = 16;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] res_num;
    logic [29:0] res_den;
    logic [31:0] whole_part;
    logic [30:0] frac_num;
  } frac_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic [1:0] in_cmd = CMD_ADD;
  logic signed [W-1:0] in_a_num = '0, in_a_den = '0, in_b_num = '0, in_b_den = '0;
  wire busy, out_valid;
  wire [1:0] out_status;
  wire signed [RES_NUM_W-1:0] out_res_num;
  wire [RES_DEN_W-1:0] out_res_den;
  wire signed [WHOLE_W-1:0] out_whole_part;
  wire signed [FRAC_NUM_W-1:0] out_frac_num;

  frac_result_t pending_results[$];
  int errors = 0;
  int words_sent = 0;
  int words_checked = 0;
  int idle_cycles = 0;
  bit quiet_sender = 1'b0;

  rational_fraction_alu #(.OPERAND_WIDTH(W)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_a_num(in_a_num), .in_a_den(in_a_den),
    .in_b_num(in_b_num), .in_b_den(in_b_den),
    .out_valid(out_valid), .out_status(out_status), .out_res_num(out_res_num),
    .out_res_den(out_res_den), .out_whole_part(out_whole_part),
    .out_frac_num(out_frac_num)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint unsigned gcd64(longint unsigned x, longint unsigned y);
    longint unsigned t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic frac_result_t predict_fraction(logic [1:0] op, logic [W-1:0] an_raw,
      logic [W-1:0] ad_raw, logic [W-1:0] bn_raw, logic [W-1:0] bd_raw);
    frac_result_t r;
    longint signed an, ad, bn, bd, n, d, l, g, q, m;
    r = '0;
    r.status = ST_OK;
    an = longint'($signed(an_raw));
    ad = longint'($signed(ad_raw));
    bn = longint'($signed(bn_raw));
    bd = longint'($signed(bd_raw));
    if (ad == 0 || bd == 0) begin
      r.status = ST_ZERO_DEN;
      return r;
    end
    if (ad < 0) begin
      an = -an;
      ad = -ad;
    end
    if (bd < 0) begin
      bn = -bn;
      bd = -bd;
    end
    case (op) inside
      CMD_ADD, CMD_SUB: begin
        l = (ad / longint'(gcd64(ad, bd))) * bd;
        if (op == CMD_SUB) bn = -bn;
        n = an * (l / ad) + bn * (l / bd);
        d = l;
      end
      CMD_MUL: begin
        n = an * bn;
        d = ad * bd;
      end
      default: begin
        if (bn == 0) begin
          r.status = ST_DIV_ZERO;
          return r;
        end
        n = an * bd;
        d = ad * bn;
        if (d < 0) begin
          n = -n;
          d = -d;
        end
      end
    endcase
    if (n == 0) begin
      d = 1;
    end else begin
      m = (n < 0) ? -n : n;
      g = longint'(gcd64(m, d));
      n = n / g;
      d = d / g;
    end
    q = n / d;
    r.res_num = n[31:0];
    r.res_den = d[29:0];
    r.whole_part = q[31:0];
    l = n - q * d;
    r.frac_num = l[30:0];
    return r;
  endfunction

  task automatic send_word(logic [1:0] op, logic [W-1:0] an, logic [W-1:0] ad,
      logic [W-1:0] bn, logic [W-1:0] bd);
    while (!quiet_sender && $urandom_range(99) < 21) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_cmd <= op;
    in_a_num <= an;
    in_a_den <= ad;
    in_b_num <= bn;
    in_b_den <= bd;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(predict_fraction(op, an, ad, bn, bd));
    words_sent++;
  endtask

  function automatic logic [W-1:0] random_operand();
    case ($urandom_range(5))
      0: return logic'(W'($urandom_range(4))) ? W'($urandom_range(4)) : '0;
      1: return W'(-$signed(32'($urandom_range(9))));
      2: return 16'h8000;
      3: return 16'h7fff;
      default: return W'($urandom);
    endcase
  endfunction

  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic test_directed();
    logic [1:0] op;
    for (int i = 0; i < 4; i++) begin
      op = 2'(i);
      send_word(op, 16'sd1, 16'sd2, 16'sd1, 16'sd3);
      send_word(op, 16'h7fff, 16'h8001, 16'h8000, 16'h7fff);
      send_word(op, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_word(op, 16'sd0, 16'sd5, 16'sd7, -16'sd5);
      send_word(op, 16'sd3, 16'sd0, 16'sd1, 16'sd1);
    end
    send_word(CMD_DIV, 16'sd4, 16'sd9, 16'sd0, 16'sd7);
    send_word(CMD_MUL, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_word(CMD_SUB, 16'sd5, 16'sd6, 16'sd5, 16'sd6);
  endtask

  task automatic test_wait_for_empty();
    drain_results();
    send_word(CMD_ADD, -16'sd7, 16'sd4, 16'sd3, -16'sd8);
    drain_results();
  endtask

  task automatic test_random(int count, bit no_idle);
    quiet_sender = no_idle;
    for (int i = 0; i < count; i++)
      send_word(2'($urandom_range(3)), random_operand(), random_operand(),
        random_operand(), random_operand());
    quiet_sender = 1'b0;
  endtask

  always @(posedge clk) begin
    frac_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result word with none expected");
        errors++;
      end else begin
        want = pending_results.pop_front();
        words_checked++;
        if (out_status !== want.status) begin
          $error("status exp %0d got %0d", want.status, out_status);
          errors++;
        end
        if (out_res_num !== want.res_num) begin
          $error("res_num exp %0d got %0d", $signed(want.res_num), out_res_num);
          errors++;
        end
        if (out_res_den !== want.res_den) begin
          $error("res_den exp %0d got %0d", want.res_den, out_res_den);
          errors++;
        end
        if (out_whole_part !== want.whole_part) begin
          $error("whole_part exp %0d got %0d", $signed(want.whole_part), out_whole_part);
          errors++;
        end
        if (out_frac_num !== want.frac_num) begin
          $error("frac_num exp %0d got %0d", $signed(want.frac_num), out_frac_num);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("rational_fraction_alu test failed");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_wait_for_empty();
    test_random(300, 1'b1);
    test_random(900, 1'b0);
    drain_results();
    $display("Covered %0d words over all four operations, zero denominators,", words_sent);
    $display("divide by zero, extreme operands; %0d results checked.", words_checked);
    if (errors == 0) $display("rational_fraction_alu test passed");
    else $display("rational_fraction_alu test failed");
    $finish;
  end

endmodule
`default_nettype wire

// File: rational_fraction_alu.f
rtl/core/rfa_pkg.sv
rtl/core/rfa_front.sv
rtl/core/rfa_queue.sv
rtl/core/rfa_div.sv
rtl/core/rfa_back.sv
rtl/core/rational_fraction_alu.sv
rtl/core/rfa_checker.sv
tb/tb_top.sv
